// ===== rtl/sobt_pkg.sv =====
// sobt_pkg: shared types, command and status codes for the sorted offset mark table
// no dependencies
package sobt_pkg;

    localparam int MaxMarksDefault = 64;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_ADJREP = 3'd2;
    localparam logic [2:0] CMD_ADJSWP = 3'd3;
    localparam logic [2:0] CMD_LOOKUP = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [31:0] INVALID_OFS = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  cmd;
        logic signed [31:0] offset;
        logic [15:0] tag;
        logic [30:0] second_start;
        logic [30:0] removed_len;
        logic [30:0] inserted_len;
        logic [30:0] part_len;
        logic [5:0]  index;
    } sobt_in_t;

    typedef struct packed {
        logic        found;
        logic signed [31:0] out_offset;
        logic [15:0] out_tag;
        logic        changed;
        logic [6:0]  count;
        logic [1:0]  status;
    } sobt_out_t;

    // signed less-than on raw 32-bit words
    function automatic logic lt_s(input logic [31:0] a, input logic [31:0] b);
        lt_s = $signed(a) < $signed(b);
    endfunction

endpackage

// ===== rtl/sobt_ram.sv =====
// sobt_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module sobt_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/sorted_offset_bookmark_table.sv =====
// sorted_offset_bookmark_table: top level, sequencer over two entry memories
// depends on sobt_pkg and sobt_ram
//
// channel  | direction | handshake        | payload
// command  | in        | start / busy     | cmd_beat (sobt_in_t)
// result   | out       | done strobe      | result (sobt_out_t)
//
// every memory read is registered on a single read port, so a scan
// reads and then evaluates each entry, and moving one entry reads and writes it.
// add and remove scan, then move every later entry. adjust replaced moves the
// tail once per deleted mark; adjust swapped scans, offsets the span in one pass
// and rotates it left one entry per pass.
// reset clears the count and the sequencer; entry memories are not cleared.
// the receiver cannot stall: done is high for one cycle with the result, and
// the block then returns to idle, where the next command is taken.
module sorted_offset_bookmark_table
    import sobt_pkg::*;
#(
    parameter int MaxMarks = MaxMarksDefault
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  sobt_in_t  cmd_beat,
    output logic      done,
    output sobt_out_t result
);
    localparam int AW = $clog2(MaxMarks);
    localparam int CW = $clog2(MaxMarks + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;  // issue read of pos
    localparam logic [3:0] S_SCANW = 4'd2;  // evaluate read data
    localparam logic [3:0] S_SHUP  = 4'd3;  // shift up: read k-1
    localparam logic [3:0] S_SHUPW = 4'd4;  // write k
    localparam logic [3:0] S_SHDN  = 4'd5;  // shift down: read k+1
    localparam logic [3:0] S_SHDNW = 4'd6;  // write k
    localparam logic [3:0] S_ADD   = 4'd7;  // rewrite pos after read
    localparam logic [3:0] S_ROT   = 4'd8;  // rotate step read
    localparam logic [3:0] S_ROTW  = 4'd9;  // rotate step write
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]    state_reg, state_next;
    sobt_in_t      req_reg, req_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;     // scan position
    logic [CW-1:0] k_reg, k_next;         // shift pointer
    logic [1:0]    phase_reg, phase_next; // scan phase for adjust commands
    logic [CW-1:0] i0_reg, i0_next, i1_reg, i1_next;
    logic [CW-1:0] rot_reg, rot_next;     // rotations left (swap)
    logic [31:0]   hold_ofs_reg, hold_ofs_next;
    logic [15:0]   hold_tag_reg, hold_tag_next;
    logic          changed_reg, changed_next;
    logic          found_reg, found_next;
    logic [31:0]   oofs_reg, oofs_next;
    logic [15:0]   otag_reg, otag_next;
    logic [1:0]    status_reg, status_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wofs, rofs;
    logic [15:0]   wtag, rtag;

    sobt_ram #(.Width(32), .Depth(MaxMarks)) u_ofs (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wofs), .raddr(raddr), .rdata(rofs)
    );
    sobt_ram #(.Width(16), .Depth(MaxMarks)) u_tag (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wtag), .raddr(raddr), .rdata(rtag)
    );

    logic [31:0] q_ofs, q_end, q_second, q_behind, q_diff, q_sdiff, q_plen;
    assign q_ofs    = req_reg.offset;
    assign q_second = {1'b0, req_reg.second_start};
    assign q_plen   = {1'b0, req_reg.part_len};
    assign q_end    = q_ofs + {1'b0, req_reg.removed_len};
    assign q_behind = q_second + q_plen;
    assign q_diff   = {1'b0, req_reg.inserted_len} - {1'b0, req_reg.removed_len};
    assign q_sdiff  = q_ofs - q_second;

    assign busy = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        phase_next    = phase_reg;
        i0_next       = i0_reg;
        i1_next       = i1_reg;
        rot_next      = rot_reg;
        hold_ofs_next = hold_ofs_reg;
        hold_tag_next = hold_tag_reg;
        changed_next  = changed_reg;
        found_next    = found_reg;
        oofs_next     = oofs_reg;
        otag_next     = otag_reg;
        status_next   = status_reg;
        we    = 1'b0;
        waddr = pos_reg[AW-1:0];
        raddr = pos_reg[AW-1:0];
        wofs  = rofs;
        wtag  = rtag;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = cmd_beat;
                    pos_next     = '0;
                    phase_next   = 2'd0;
                    changed_next = 1'b0;
                    found_next   = 1'b0;
                    oofs_next    = '0;
                    otag_next    = '0;
                    status_next  = ST_OK;
                    unique case (cmd_beat.cmd)
                        CMD_ADD, CMD_REMOVE:
                        begin
                            if (cmd_beat.offset == INVALID_OFS)
                            begin
                                status_next = ST_INVALID;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_ADJREP, CMD_ADJSWP, CMD_LOOKUP:
                            state_next = S_SCAN;
                        CMD_READ:
                        begin
                            if (32'(cmd_beat.index) < 32'(count_reg))
                            begin
                                pos_next   = CW'(cmd_beat.index);
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                // address pos is read; past the end, add inserts or reports full, swap ends its phase, others finish
                if (req_reg.cmd != CMD_READ && pos_reg >= count_reg)
                begin
                    unique case (req_reg.cmd)
                        CMD_ADD:
                        begin
                            if (count_reg >= CW'(MaxMarks))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = (count_reg == pos_reg) ? S_ADD : S_SHUP;
                            end
                        end
                        CMD_ADJSWP:
                        begin
                            // end of table ends the current phase
                            if (phase_reg == 2'd0)
                            begin
                                i0_next = pos_reg;
                                i1_next = pos_reg;
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                i1_next = pos_reg;
                            end
                            phase_next = 2'd2;
                            state_next = S_SCANW;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
                else
                begin
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                state_next = S_SCAN;
                unique case (req_reg.cmd)
                    CMD_ADD:
                    begin
                        if (rofs == q_ofs)
                        begin
                            we   = 1'b1;
                            wtag = req_reg.tag;
                            state_next = S_DONE;
                        end
                        else if (lt_s(q_ofs, rofs))
                        begin
                            if (count_reg >= CW'(MaxMarks))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = S_SHUP;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (rofs == q_ofs)
                        begin
                            k_next     = pos_reg;
                            state_next = S_SHDN;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (rofs == q_ofs)
                        begin
                            found_next = 1'b1;
                            oofs_next  = rofs;
                            otag_next  = rtag;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        found_next = 1'b1;
                        oofs_next  = rofs;
                        otag_next  = rtag;
                        state_next = S_DONE;
                    end
                    CMD_ADJREP:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            // skip marks before start
                            if (lt_s(rofs, q_ofs))
                                pos_next = pos_reg + 1'b1;
                            else
                                phase_next = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            // delete marks inside the removed range
                            if (lt_s(rofs, q_end))
                            begin
                                changed_next = 1'b1;
                                k_next       = pos_reg;
                                state_next   = S_SHDN;
                            end
                            else if (q_diff == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                phase_next = 2'd2;
                            end
                        end
                        else
                        begin
                            // shift later marks
                            we           = 1'b1;
                            wofs         = rofs + q_diff;
                            changed_next = 1'b1;
                            pos_next     = pos_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        // swap: find i0, i1, i2 then rotate
                        if (phase_reg == 2'd0)
                        begin
                            if (lt_s(rofs, q_ofs))
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                            else
                            begin
                                i0_next    = pos_reg;
                                phase_next = 2'd1;
                            end
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            if (lt_s(rofs, q_second))
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                            else
                            begin
                                i1_next    = pos_reg;
                                phase_next = 2'd2;
                            end
                        end
                        else if (pos_reg < count_reg && lt_s(rofs, q_behind))
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        else
                        begin
                            // pos is i2; first offset the two parts in place
                            changed_next = (pos_reg > i0_reg);
                            k_next       = i0_reg;
                            phase_next   = 2'd3;
                            state_next   = (pos_reg > i0_reg) ? S_ROT : S_DONE;
                            rot_next     = i1_reg - i0_reg;
                        end
                    end
                endcase
            end
            S_SHUP:
            begin
                // move entry k-1 to k, down to pos
                if (k_reg == pos_reg)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    raddr      = AW'(k_reg - 1'b1);
                    state_next = S_SHUPW;
                end
            end
            S_SHUPW:
            begin
                we         = 1'b1;
                waddr      = k_reg[AW-1:0];
                k_next     = k_reg - 1'b1;
                state_next = S_SHUP;
            end
            S_ADD:
            begin
                we         = 1'b1;
                wofs       = q_ofs;
                wtag       = req_reg.tag;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_SHDN:
            begin
                // move entry k+1 to k until the end
                if (k_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = (req_reg.cmd == CMD_ADJREP) ? S_SCAN : S_DONE;
                end
                else
                begin
                    raddr      = AW'(k_reg + 1'b1);
                    state_next = S_SHDNW;
                end
            end
            S_SHDNW:
            begin
                we         = 1'b1;
                waddr      = k_reg[AW-1:0];
                k_next     = k_reg + 1'b1;
                state_next = S_SHDN;
            end
            S_ROT:
            begin
                // phase 3: add offsets in place over [i0, i2)
                // phase 2 reused: rotate left by one, rot times
                raddr      = k_reg[AW-1:0];
                state_next = S_ROTW;
            end
            default:
            begin
                if (state_reg == S_ROTW)
                begin
                    if (phase_reg == 2'd3)
                    begin
                        we    = 1'b1;
                        waddr = k_reg[AW-1:0];
                        wofs  = (k_reg < i1_reg) ? rofs + q_plen : rofs + q_sdiff;
                        if (k_reg + 1'b1 == pos_reg)
                        begin
                            phase_next = 2'd2;
                            k_next     = i0_reg;
                            state_next = (rot_reg == '0) ? S_DONE : S_ROT;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            state_next = S_ROT;
                        end
                    end
                    else if (k_reg == i0_reg)
                    begin
                        // save the head, then shift the rest down
                        hold_ofs_next = rofs;
                        hold_tag_next = rtag;
                        k_next        = k_reg + 1'b1;
                        state_next    = S_ROT;
                    end
                    else if (k_reg == pos_reg)
                    begin
                        // unreachable read slot: put head at the tail
                        we         = 1'b1;
                        waddr      = AW'(pos_reg - 1'b1);
                        wofs       = hold_ofs_reg;
                        wtag       = hold_tag_reg;
                        rot_next   = rot_reg - 1'b1;
                        k_next     = i0_reg;
                        state_next = (rot_reg == CW'(1)) ? S_DONE : S_ROT;
                    end
                    else
                    begin
                        we     = 1'b1;
                        waddr  = AW'(k_reg - 1'b1);
                        k_next = k_reg + 1'b1;
                        state_next = S_ROT;
                    end
                end
                else
                begin
                    // result beat
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        phase_reg    <= phase_next;
        i0_reg       <= i0_next;
        i1_reg       <= i1_next;
        rot_reg      <= rot_next;
        hold_ofs_reg <= hold_ofs_next;
        hold_tag_reg <= hold_tag_next;
        changed_reg  <= changed_next;
        found_reg    <= found_next;
        oofs_reg     <= oofs_next;
        otag_reg     <= otag_next;
        status_reg   <= status_next;
    end

    // result beat
    assign done              = (state_reg == S_DONE);
    assign result.found      = found_reg;
    assign result.out_offset = oofs_reg;
    assign result.out_tag    = otag_reg;
    assign result.changed    = changed_reg;
    assign result.count      = 7'(count_reg);
    assign result.status     = status_reg;
endmodule

// ===== tb/sorted_offset_bookmark_table_test.sv =====
// sorted_offset_bookmark_table_test: directed table, fill to full, then random commands against a mark table model
// depends on sobt_pkg and sorted_offset_bookmark_table
module sorted_offset_bookmark_table_test;
    import sobt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 64;
    localparam int WatchLimit = 60000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    sobt_in_t  cmd_beat = '0;
    logic      done;
    sobt_out_t result;

    sorted_offset_bookmark_table uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd_beat(cmd_beat), .done(done), .result(result)
    );

    always #5 clk = ~clk;

    // table model state
    logic [31:0] tbl_ofs [Depth];
    logic [15:0] tbl_tag [Depth];
    int          tbl_n;

    sobt_out_t pending_results[$];
    int        fails = 0;
    int        quiet = 0;

    function automatic logic slt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic void drop_at(int pos);
        for (int k = pos; k + 1 < tbl_n; k++)
        begin
            tbl_ofs[k] = tbl_ofs[k + 1];
            tbl_tag[k] = tbl_tag[k + 1];
        end
        tbl_n--;
    endfunction

    // compute the result beat of one command and update the table
    function automatic sobt_out_t apply_mark_cmd(sobt_in_t c);
        sobt_out_t   r;
        int          i, i0, i1, i2, n;
        logic [31:0] lim, diff, plen;
        logic [31:0] t_ofs [Depth];
        logic [15:0] t_tag [Depth];
        r = '0;
        case (c.cmd)
            CMD_ADD:
            begin
                if (c.offset == INVALID_OFS)
                    r.status = ST_INVALID;
                else
                begin
                    for (i = 0; i < tbl_n; i++)
                        if (!slt(tbl_ofs[i], c.offset))
                            break;
                    if (i < tbl_n && tbl_ofs[i] == c.offset)
                        tbl_tag[i] = c.tag;
                    else if (tbl_n >= Depth)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int k = tbl_n; k > i; k--)
                        begin
                            tbl_ofs[k] = tbl_ofs[k - 1];
                            tbl_tag[k] = tbl_tag[k - 1];
                        end
                        tbl_ofs[i] = c.offset;
                        tbl_tag[i] = c.tag;
                        tbl_n++;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (c.offset == INVALID_OFS)
                    r.status = ST_INVALID;
                else
                    for (i = 0; i < tbl_n; i++)
                        if (tbl_ofs[i] == c.offset)
                        begin
                            drop_at(i);
                            break;
                        end
            end
            CMD_ADJREP:
            begin
                lim = c.offset + {1'b0, c.removed_len};
                diff = {1'b0, c.inserted_len} - {1'b0, c.removed_len};
                i = 0;
                while (i < tbl_n && slt(tbl_ofs[i], c.offset))
                    i++;
                while (i < tbl_n && slt(tbl_ofs[i], lim))
                begin
                    drop_at(i);
                    r.changed = 1'b1;
                end
                if (diff != 0)
                    for (; i < tbl_n; i++)
                    begin
                        tbl_ofs[i] += diff;
                        r.changed = 1'b1;
                    end
            end
            CMD_ADJSWP:
            begin
                plen = {1'b0, c.part_len};
                diff = c.offset - {1'b0, c.second_start};
                lim = {1'b0, c.second_start} + plen;
                i0 = 0;
                while (i0 < tbl_n && slt(tbl_ofs[i0], c.offset))
                    i0++;
                i1 = i0;
                while (i1 < tbl_n && slt(tbl_ofs[i1], {1'b0, c.second_start}))
                    i1++;
                i2 = i1;
                while (i2 < tbl_n && slt(tbl_ofs[i2], lim))
                    i2++;
                n = 0;
                for (int k = i1; k < i2; k++)
                begin
                    t_ofs[n] = tbl_ofs[k] + diff;
                    t_tag[n] = tbl_tag[k];
                    n++;
                end
                for (int k = i0; k < i1; k++)
                begin
                    t_ofs[n] = tbl_ofs[k] + plen;
                    t_tag[n] = tbl_tag[k];
                    n++;
                end
                for (int k = 0; k < n; k++)
                begin
                    tbl_ofs[i0 + k] = t_ofs[k];
                    tbl_tag[i0 + k] = t_tag[k];
                end
                r.changed = i2 > i0;
            end
            CMD_LOOKUP:
            begin
                for (i = 0; i < tbl_n; i++)
                    if (tbl_ofs[i] == c.offset)
                    begin
                        r.found = 1'b1;
                        r.out_offset = tbl_ofs[i];
                        r.out_tag = tbl_tag[i];
                        break;
                    end
            end
            CMD_READ:
            begin
                if (c.index < tbl_n)
                begin
                    r.found = 1'b1;
                    r.out_offset = tbl_ofs[c.index];
                    r.out_tag = tbl_tag[c.index];
                end
                else
                    r.status = ST_RANGE;
            end
            default:
            begin
            end
        endcase
        r.count = tbl_n[6:0];
        return r;
    endfunction

    // result checker, also counts quiet cycles for the watchdog
    always @(posedge clk)
    begin
        sobt_out_t want;
        if (done)
        begin
            quiet <= 0;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.found !== want.found)
                begin
                    $error("found exp %0d got %0d", want.found, result.found);
                    fails++;
                end
                if (result.out_offset !== want.out_offset)
                begin
                    $error("out_offset exp %h got %h", want.out_offset, result.out_offset);
                    fails++;
                end
                if (result.out_tag !== want.out_tag)
                begin
                    $error("out_tag exp %h got %h", want.out_tag, result.out_tag);
                    fails++;
                end
                if (result.changed !== want.changed)
                begin
                    $error("changed exp %0d got %0d", want.changed, result.changed);
                    fails++;
                end
                if (result.count !== want.count)
                begin
                    $error("count exp %0d got %0d", want.count, result.count);
                    fails++;
                end
                if (result.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, result.status);
                    fails++;
                end
            end
        end
        else if (start && !busy)
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (quiet >= WatchLimit)
        begin
            $display("sorted_offset_bookmark_table_test NOT OK");
            $finish;
        end
    end

    bit        idle_on = 1'b1;
    sobt_out_t no_check;

    // drive one command beat, hold until accepted; typed result checked too
    // start stays high after the beat until the next beat or an idle gap
    task automatic send_beat(sobt_in_t c, bit typed, sobt_out_t typed_r);
        sobt_out_t p;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_beat <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = apply_mark_cmd(c);
        if (typed && p !== typed_r)
        begin
            $error("directed row cmd %0d exp %h model %h", c.cmd, typed_r, p);
            fails++;
        end
        pending_results.push_back(p);
    endtask

    function automatic sobt_in_t mk(logic [2:0] c, logic [31:0] o, logic [15:0] t);
        sobt_in_t b;
        b = '0;
        b.cmd = c;
        b.offset = o;
        b.tag = t;
        return b;
    endfunction

    function automatic sobt_out_t rs(logic f, logic [31:0] o, logic [15:0] t,
                                     logic [6:0] n, logic [1:0] s);
        sobt_out_t r;
        r = '0;
        r.found = f;
        r.out_offset = o;
        r.out_tag = t;
        r.count = n;
        r.status = s;
        return r;
    endfunction

    // random offset in a small window, near an extreme or anywhere
    function automatic logic [31:0] rnd_ofs();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(0, 40);
            2: return 32'h8000_0000 + $urandom_range(0, 40);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [30:0] rnd_len();
        case ($urandom_range(0, 7))
            0: return 31'($urandom());
            1: return 31'h7FFF_FFFF;
            2: return 31'd0;
            default: return 31'($urandom_range(0, 60));
        endcase
    endfunction

    sobt_in_t  rows_in [$];
    sobt_out_t rows_out [$];
    bit        rows_typed [$];

    initial
    begin
        sobt_in_t b;
        no_check = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows_in.push_back(mk(CMD_READ, 0, 0));
        rows_out.push_back(rs(0, 0, 0, 0, ST_RANGE)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 0));
        rows_out.push_back(rs(0, 0, 0, 0, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF));
        rows_out.push_back(rs(0, 0, 0, 0, ST_INVALID)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_REMOVE, 32'hFFFF_FFFF, 0));
        rows_out.push_back(rs(0, 0, 0, 0, ST_INVALID)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_ADD, 32'h7FFF_FFFF, 16'hFFFF));
        rows_out.push_back(rs(0, 0, 0, 1, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_ADD, 32'h8000_0000, 16'h0000));
        rows_out.push_back(rs(0, 0, 0, 2, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_ADD, 0, 16'hA5A5));
        rows_out.push_back(rs(0, 0, 0, 3, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_READ, 0, 0));
        rows_out.push_back(rs(1, 32'h8000_0000, 0, 3, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_ADD, 0, 16'h5A5A));
        rows_out.push_back(rs(0, 0, 0, 3, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_LOOKUP, 0, 0));
        rows_out.push_back(rs(1, 0, 16'h5A5A, 3, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_REMOVE, 12345, 0));
        rows_out.push_back(rs(0, 0, 0, 3, ST_OK)); rows_typed.push_back(1);
        rows_in.push_back(mk(CMD_ADD, 100, 1)); rows_out.push_back(no_check);
        rows_typed.push_back(0);
        rows_in.push_back(mk(CMD_ADD, 200, 2)); rows_out.push_back(no_check);
        rows_typed.push_back(0);
        b = mk(CMD_ADJREP, 90, 0); b.removed_len = 31'd20; b.inserted_len = 31'd5;
        rows_in.push_back(b); rows_out.push_back(no_check); rows_typed.push_back(0);
        b = mk(CMD_ADJREP, 0, 0); b.removed_len = 31'h7FFF_FFFF; b.inserted_len = 31'd0;
        rows_in.push_back(b); rows_out.push_back(no_check); rows_typed.push_back(0);
        b = mk(CMD_ADJSWP, 32'h8000_0000, 0); b.second_start = 31'd50;
        b.part_len = 31'h7FFF_FFFF;
        rows_in.push_back(b); rows_out.push_back(no_check); rows_typed.push_back(0);
        b = mk(CMD_ADJREP, 32'h7FFF_FFF0, 0); b.inserted_len = 31'h7FFF_FFFF;
        rows_in.push_back(b); rows_out.push_back(no_check); rows_typed.push_back(0);
        b = mk(CMD_READ, 0, 0); b.index = 6'd63;
        rows_in.push_back(b); rows_out.push_back(no_check); rows_typed.push_back(0);
        b = mk(3'd6, 5, 5); rows_in.push_back(b); rows_out.push_back(no_check);
        rows_typed.push_back(0);
        b = mk(3'd7, 5, 5); rows_in.push_back(b); rows_out.push_back(no_check);
        rows_typed.push_back(0);
        foreach (rows_in[r])
            send_beat(rows_in[r], rows_typed[r], rows_out[r]);

        // fill to full and overflow
        for (int k = 0; k < 70; k++)
            send_beat(mk(CMD_ADD, 1000 + 3 * k, 16'(k)), 0, no_check);
        send_beat(mk(CMD_ADD, 1000, 16'hBEEF), 0, no_check);
        b = mk(CMD_READ, 0, 0); b.index = 6'd63;
        send_beat(b, 0, no_check);

        // hold off until every result is back
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        // random part, with adds favoured so the table fills up
        for (int n = 0; n < 1300; n++)
        begin
            b = '0;
            b.cmd = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 2) == 0)
                b.cmd = CMD_ADD;
            b.offset = ($urandom_range(0, 30) == 0) ? 32'hFFFF_FFFF : rnd_ofs();
            b.tag = 16'($urandom());
            b.second_start = (b.cmd == CMD_ADJSWP && $urandom_range(0, 1)) ?
                              31'(b.offset[30:0] + $urandom_range(0, 60)) :
                              31'($urandom_range(0, 300));
            if ($urandom_range(0, 9) == 0)
                b.second_start = 31'($urandom());
            b.removed_len = rnd_len();
            b.inserted_len = rnd_len();
            b.part_len = rnd_len();
            b.index = 6'($urandom());
            if (n >= 1100)
                idle_on = 1'b0;
            send_beat(b, 0, no_check);
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fails == 0)
            $display("sorted_offset_bookmark_table_test OK");
        else
            $display("sorted_offset_bookmark_table_test NOT OK");
        $finish;
    end

endmodule
